// ----- src/segment_lcd_serial_frame_writer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the segment LCD serial frame writer
// Clocked implication checks that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_LCD_SERIAL_FRAME_WRITER_CORE_ASSERT_SVH
`define SEGMENT_LCD_SERIAL_FRAME_WRITER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/slcd_pkg.sv -----
// ---------------------------------------------------------------------------
// slcd_pkg
// Shared types, codes and frame builders for the serial frame writer.
// ---------------------------------------------------------------------------
package slcd_pkg;

    localparam int SHADOW_DEPTH = 16;
    localparam int SHADOW_AW    = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

    localparam int FRAME_W = 13;
    localparam int CNT_W   = 4;

    localparam logic [CNT_W-1:0] LEN_CMD = CNT_W'(12);
    localparam logic [CNT_W-1:0] LEN_WR  = CNT_W'(13);

    localparam logic [2:0] HEAD_CMD = 3'b100;
    localparam logic [2:0] HEAD_WR  = 3'b101;

    localparam logic [1:0] FUNC_CMD   = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_CACHE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic has_frame;
        logic last_bit;
        logic out_free;
    } t_sts;

    // Command frame, left aligned: head, command MSB first, trailing zero, pad.
    function automatic logic [FRAME_W-1:0] f_cmd_frame(input logic [7:0] code);
        f_cmd_frame = {HEAD_CMD, code, 1'b0, 1'b0};
    endfunction

    // Write frame: head, address MSB first, nibble LSB first.
    function automatic logic [FRAME_W-1:0] f_wr_frame(input logic [5:0] addr,
                                                       input logic [3:0] nib);
        f_wr_frame = {HEAD_WR, addr, nib[0], nib[1], nib[2], nib[3]};
    endfunction

endpackage

// ----- src/slcd_ctl.sv -----
// ---------------------------------------------------------------------------
// slcd_ctl
// Controller: accepts a request word and sequences the bit stream.
// ---------------------------------------------------------------------------
module slcd_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  slcd_pkg::t_sts i_sts,
    output slcd_pkg::t_cmd o_cmd
);

    slcd_pkg::t_state r_state;
    slcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            slcd_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid && i_sts.has_frame) begin
                    n_state = slcd_pkg::ST_SEND;
                end
            end
            slcd_pkg::ST_SEND: begin
                o_cmd.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.last_bit) begin
                    n_state = slcd_pkg::ST_IDLE;
                end
            end
            default: n_state = slcd_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- src/slcd_dp.sv -----
// ---------------------------------------------------------------------------
// slcd_dp
// Datapath: shadow bytes, frame shift registers and the output register.
// ---------------------------------------------------------------------------
module slcd_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  slcd_pkg::t_cmd i_cmd,
    output slcd_pkg::t_sts o_sts,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_command_code,
    input  logic [5:0]    i_nibble_address,
    input  logic [3:0]    i_nibble_value,
    input  logic [3:0]    i_byte_index,
    input  logic [7:0]    i_byte_value,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic          o_serial_bit,
    output logic          o_frame_end,
    output logic          o_last
);

    logic [7:0]                     r_shadow [slcd_pkg::SHADOW_DEPTH];
    logic [slcd_pkg::FRAME_W-1:0]   r_frame;
    logic [slcd_pkg::FRAME_W-1:0]   r_frame_b;
    logic [slcd_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_pend;
    logic                           r_ovalid;
    logic                           r_obit;
    logic                           r_ofend;
    logic                           r_olast;

    logic [slcd_pkg::FRAME_W-1:0]   n_frame;
    logic [slcd_pkg::FRAME_W-1:0]   n_frame_b;
    logic [slcd_pkg::CNT_W-1:0]     n_cnt;
    logic                           n_pend;
    logic                           has_frame;
    logic                           in_range;
    logic                           lo_chg;
    logic                           hi_chg;
    logic                           shadow_we;
    logic [slcd_pkg::SHADOW_AW-1:0] idx;
    logic [7:0]                     old_byte;
    logic [5:0]                     lo_addr;
    logic [5:0]                     hi_addr;

    assign idx      = i_byte_index[slcd_pkg::SHADOW_AW-1:0];
    assign in_range = 32'(i_byte_index) < 32'(slcd_pkg::SHADOW_DEPTH);
    assign old_byte = r_shadow[idx];
    assign lo_chg   = in_range && (i_byte_value[3:0] != old_byte[3:0]);
    assign hi_chg   = in_range && (i_byte_value[7:4] != old_byte[7:4]);
    assign lo_addr  = {1'b0, i_byte_index, 1'b0};
    assign hi_addr  = {1'b0, i_byte_index, 1'b1};

    // Decode the request into zero, one or two frames.
    always_comb begin
        has_frame = 1'b0;
        n_frame   = '0;
        n_frame_b = slcd_pkg::f_wr_frame(hi_addr, i_byte_value[7:4]);
        n_cnt     = slcd_pkg::LEN_WR;
        n_pend    = 1'b0;
        shadow_we = 1'b0;
        unique case (i_func)
            slcd_pkg::FUNC_CMD: begin
                has_frame = 1'b1;
                n_frame   = slcd_pkg::f_cmd_frame(i_command_code);
                n_cnt     = slcd_pkg::LEN_CMD;
            end
            slcd_pkg::FUNC_WRITE: begin
                has_frame = 1'b1;
                n_frame   = slcd_pkg::f_wr_frame(i_nibble_address, i_nibble_value);
            end
            slcd_pkg::FUNC_CACHE: begin
                has_frame = lo_chg || hi_chg;
                n_pend    = lo_chg && hi_chg;
                shadow_we = in_range;
                n_frame   = lo_chg ? slcd_pkg::f_wr_frame(lo_addr, i_byte_value[3:0])
                                   : n_frame_b;
            end
            default: has_frame = 1'b0;
        endcase
    end

    assign o_sts.has_frame = has_frame;
    assign o_sts.last_bit  = (r_cnt == slcd_pkg::CNT_W'(1)) && !r_pend;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < slcd_pkg::SHADOW_DEPTH; i++) begin
                r_shadow[i] <= '0;
            end
        end else if (i_cmd.load && shadow_we) begin
            r_shadow[idx] <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= n_pend;
                r_cnt  <= n_cnt;
            end else if (i_cmd.step) begin
                if (r_cnt == slcd_pkg::CNT_W'(1)) begin
                    r_pend <= 1'b0;
                    r_cnt  <= slcd_pkg::LEN_WR;
                end else begin
                    r_cnt <= r_cnt - slcd_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.step) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame   <= n_frame;
            r_frame_b <= n_frame_b;
        end else if (i_cmd.step) begin
            if (r_cnt == slcd_pkg::CNT_W'(1)) begin
                r_frame <= r_frame_b;
            end else begin
                r_frame <= {r_frame[slcd_pkg::FRAME_W-2:0], 1'b0};
            end
        end
        if (i_cmd.step) begin
            r_obit  <= r_frame[slcd_pkg::FRAME_W-1];
            r_ofend <= r_cnt == slcd_pkg::CNT_W'(1);
            r_olast <= (r_cnt == slcd_pkg::CNT_W'(1)) && !r_pend;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_serial_bit = r_obit;
    assign o_frame_end  = r_ofend;
    assign o_last       = r_olast;

endmodule

// ----- src/segment_lcd_serial_frame_writer_core.sv -----
// ---------------------------------------------------------------------------
// segment_lcd_serial_frame_writer_core
// Turns display requests into the serial bit stream of a three-wire LCD link.
// ---------------------------------------------------------------------------
// The input channel (i_valid / o_ready) takes one request word: a command
// frame, a raw nibble write or a cached byte update. The output channel
// (o_valid / i_ready) hands out one word per serial data bit, with
// o_frame_end on the final bit of each frame and o_last on the final bit
// caused by the request.
// A command frame is 12 bits and a write frame 13 bits; a cached update
// sends up to two write frames, so one request yields 0 to 26 words.
// The first bit reaches the output register from the frame shift register
// after acceptance, and one bit follows per cycle while the receiver takes
// them; the single shift register that walks each frame hands every bit
// to the output register. A request that yields no words (unused function
// code, out-of-range index or unchanged byte) leaves the controller idle.
// A new request is taken as soon as the previous one has moved its final
// bit into the output register, even while that bit waits to be taken.
// When the receiver stalls, the output register holds its word and the
// shift register waits. Reset clears the shadow bytes to zero, empties the
// output register and returns the controller to idle.
// ---------------------------------------------------------------------------
`include "segment_lcd_serial_frame_writer_core_assert.svh"

module segment_lcd_serial_frame_writer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_command_code,
    input  logic [5:0] i_nibble_address,
    input  logic [3:0] i_nibble_value,
    input  logic [3:0] i_byte_index,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_serial_bit,
    output logic       o_frame_end,
    output logic       o_last
);

    // Command and status between the controller and the datapath.
    slcd_pkg::t_cmd cmd;
    slcd_pkg::t_sts sts;

    slcd_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    slcd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (i_func),
        .i_command_code   (i_command_code),
        .i_nibble_address (i_nibble_address),
        .i_nibble_value   (i_nibble_value),
        .i_byte_index     (i_byte_index),
        .i_byte_value     (i_byte_value),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_serial_bit     (o_serial_bit),
        .o_frame_end      (o_frame_end),
        .o_last           (o_last)
    );

    // The final word of a request always closes a frame.
    `SLCD_ASSERT_IMP(a_last_ends_frame, i_clk, i_rst_n, o_valid && o_last, o_frame_end, "last word without frame end")

    // A command request always produces bits, so the block must be busy next.
    `SLCD_ASSERT_NXT(a_cmd_busy, i_clk, i_rst_n, i_valid && o_ready && (i_func == slcd_pkg::FUNC_CMD), !o_ready, "idle after command request")

    // The end of a first frame with a second still to come keeps the block busy.
    `SLCD_ASSERT_IMP(a_pend_busy, i_clk, i_rst_n, o_valid && o_frame_end && !o_last, !o_ready, "request taken with frame pending")

endmodule

// ----- tb/tb_segment_lcd_serial_frame_writer_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for segment_lcd_serial_frame_writer_core
// Drives command frames, raw nibble writes and cached byte updates through
// the request channel, predicts the serial bit stream each request causes
// and compares every accepted output word with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_segment_lcd_serial_frame_writer_core;

    // The block decodes three function codes; the fourth is ignored.
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 110;
    localparam int         IDLE_PCT     = 14;
    localparam int         CYCLE_LIMIT  = 100000;
    localparam int         TAIL_CYCLES  = 16;
    localparam int         REPORT_MAX   = 10;

    // One request word as it appears on the input ports.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] command_code;
        logic [5:0] nibble_address;
        logic [3:0] nibble_value;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
    } t_lcd_request;

    // One serial data bit as it appears on the output ports.
    typedef struct packed {
        logic serial_bit;
        logic frame_end;
        logic last_bit;
    } t_lcd_strobe;

    // Predicts the serial stream of the display link. It keeps its own copy
    // of the shadow bytes and a queue of the strobes still to come.
    class lcd_stream_predictor;
        logic [7:0]  shadow_bytes[slcd_pkg::SHADOW_DEPTH];
        t_lcd_strobe pending_bits[$];
        t_lcd_strobe request_bits[$];
        int          mismatch_count;
        int          strobe_count;

        function new();
            foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
            mismatch_count = 0;
            strobe_count   = 0;
        endfunction

        function void add_strobe(logic bit_value, logic frame_end);
            t_lcd_strobe s;
            s.serial_bit = bit_value;
            s.frame_end  = frame_end;
            s.last_bit   = 1'b0;
            request_bits.push_back(s);
        endfunction

        // Write frame: head, six address bits MSB first, then the nibble
        // LSB first with the frame end flag on its top bit.
        function void add_write_frame(logic [5:0] addr, logic [3:0] nib);
            for (int i = 2; i >= 0; i--) add_strobe(slcd_pkg::HEAD_WR[i], 1'b0);
            for (int i = 5; i >= 0; i--) add_strobe(addr[i], 1'b0);
            for (int i = 0; i < 4; i++) add_strobe(nib[i], logic'(i == 3));
        endfunction

        // Called for every request word taken by the block.
        function void take_request(t_lcd_request rq);
            logic [11:0] cmd_bits;
            logic [7:0]  held;
            logic [5:0]  low_addr;
            request_bits.delete();
            case (rq.func)
                slcd_pkg::FUNC_CMD: begin
                    // Head, command MSB first and a trailing zero.
                    cmd_bits = {slcd_pkg::HEAD_CMD, rq.command_code, 1'b0};
                    for (int i = 11; i >= 0; i--) begin
                        add_strobe(cmd_bits[i], logic'(i == 0));
                    end
                end
                slcd_pkg::FUNC_WRITE: begin
                    add_write_frame(rq.nibble_address, rq.nibble_value);
                end
                slcd_pkg::FUNC_CACHE: begin
                    if (int'(rq.byte_index) < slcd_pkg::SHADOW_DEPTH) begin
                        held     = shadow_bytes[rq.byte_index];
                        low_addr = {1'b0, rq.byte_index, 1'b0};
                        if (rq.byte_value[3:0] != held[3:0]) begin
                            add_write_frame(low_addr, rq.byte_value[3:0]);
                        end
                        if (rq.byte_value[7:4] != held[7:4]) begin
                            add_write_frame(low_addr | 6'd1, rq.byte_value[7:4]);
                        end
                        shadow_bytes[rq.byte_index] = rq.byte_value;
                    end
                end
                default: begin
                end
            endcase
            if (request_bits.size() > 0) begin
                request_bits[request_bits.size() - 1].last_bit = 1'b1;
            end
            foreach (request_bits[i]) pending_bits.push_back(request_bits[i]);
        endfunction

        // Called for every output word taken from the block.
        function void check_strobe(t_lcd_strobe got);
            t_lcd_strobe want;
            strobe_count++;
            if (pending_bits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("ERROR: output word %0d arrived with none predicted: %s",
                             strobe_count,
                             $sformatf("bit=%0b end=%0b last=%0b",
                                       got.serial_bit, got.frame_end, got.last_bit));
                end
            end else begin
                want = pending_bits.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("ERROR: output word %0d: expected %s, got %s",
                                 strobe_count,
                                 $sformatf("bit=%0b end=%0b last=%0b", want.serial_bit,
                                           want.frame_end, want.last_bit),
                                 $sformatf("bit=%0b end=%0b last=%0b", got.serial_bit,
                                           got.frame_end, got.last_bit));
                    end
                end
            end
        endfunction
    endclass

    // Clock, reset and the block's ports. Every input starts at a known level.
    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic       o_ready;
    logic [1:0] i_func           = '0;
    logic [7:0] i_command_code   = '0;
    logic [5:0] i_nibble_address = '0;
    logic [3:0] i_nibble_value   = '0;
    logic [3:0] i_byte_index     = '0;
    logic [7:0] i_byte_value     = '0;
    logic       o_valid;
    logic       i_ready          = 1'b0;
    logic       o_serial_bit;
    logic       o_frame_end;
    logic       o_last;

    int cycle_count = 0;

    lcd_stream_predictor predictor = new();

    segment_lcd_serial_frame_writer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_command_code   (i_command_code),
        .i_nibble_address (i_nibble_address),
        .i_nibble_value   (i_nibble_value),
        .i_byte_index     (i_byte_index),
        .i_byte_value     (i_byte_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_serial_bit     (o_serial_bit),
        .o_frame_end      (o_frame_end),
        .o_last           (o_last)
    );

    // A 12 ns clock: high for 6 ns, low for 6 ns.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The run is cut short if it hangs, for instance when the block stops
    // producing the words that are still predicted.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver stalls in about one cycle in seven, except in a quiet
    // window where it takes every word offered. The ready line changes on
    // the falling edge so that it is settled well before the block samples
    // it.
    always @(negedge i_clk) begin
        if (cycle_count >= 600 && cycle_count < 1400) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every word that crosses the output channel is checked at the rising
    // edge at which it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            predictor.check_strobe('{o_serial_bit, o_frame_end, o_last});
        end
    end

    // Builds a request with random noise in every field, then sets the
    // fields that matter to the given function. For a command the data
    // argument is the command code; for a raw write the address argument
    // and the low four data bits are used; for a cached update the low four
    // address bits give the index and the data argument the new byte.
    function automatic t_lcd_request shaped_request(input logic [1:0] func,
                                                    input logic [7:0] data,
                                                    input logic [5:0] addr);
        t_lcd_request rq;
        rq.func           = func;
        rq.command_code   = 8'($urandom);
        rq.nibble_address = 6'($urandom);
        rq.nibble_value   = 4'($urandom);
        rq.byte_index     = 4'($urandom);
        rq.byte_value     = 8'($urandom);
        case (func)
            slcd_pkg::FUNC_CMD: begin
                rq.command_code = data;
            end
            slcd_pkg::FUNC_WRITE: begin
                rq.nibble_address = addr;
                rq.nibble_value   = data[3:0];
            end
            slcd_pkg::FUNC_CACHE: begin
                rq.byte_index = addr[3:0];
                rq.byte_value = data;
            end
            default: begin
            end
        endcase
        return rq;
    endfunction

    // Offers one request word. It is called at a falling edge and returns
    // at the falling edge after the word has been taken, leaving valid high
    // so that a following word can go out back to back.
    task automatic offer_request(input t_lcd_request rq, input bit may_idle);
        while (may_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_func           = rq.func;
        i_command_code   = rq.command_code;
        i_nibble_address = rq.nibble_address;
        i_nibble_value   = rq.nibble_value;
        i_byte_index     = rq.byte_index;
        i_byte_value     = rq.byte_value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predictor.take_request(rq);
        @(negedge i_clk);
    endtask

    initial begin
        t_lcd_request rq;
        int           counted;
        int           pick;
        logic [1:0]   func;
        logic [3:0]   idx;
        logic [7:0]   held;

        // Synchronous reset held from the start of the run, released on a falling
        // edge.
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: extreme command codes, extreme addresses and
        // nibbles, and the cached update cases.
        offer_request(shaped_request(slcd_pkg::FUNC_CMD,   8'h00, 6'd0),  1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_CMD,   8'hff, 6'd0),  1'b0);
        offer_request(shaped_request(slcd_pkg::FUNC_CMD,   8'ha5, 6'd0),  1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_WRITE, 8'h00, 6'd0),  1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_WRITE, 8'h0f, 6'd63), 1'b0);
        offer_request(shaped_request(slcd_pkg::FUNC_WRITE, 8'h05, 6'h2a), 1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_WRITE, 8'h0a, 6'h15), 1'b0);
        // A byte equal to the cleared shadow entry sends nothing.
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'h00, 6'd0),  1'b1);
        // Low nibble only, then high nibble only, then no change at all.
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'h0f, 6'd0),  1'b0);
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'hff, 6'd0),  1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'hff, 6'd0),  1'b0);
        // Both nibbles change at the top index, twice in a row.
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'ha5, 6'd15), 1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'h5a, 6'd15), 1'b0);
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'h5a, 6'd15), 1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'h30, 6'd7),  1'b1);
        // Back to all zeros clears both nibbles again.
        offer_request(shaped_request(slcd_pkg::FUNC_CACHE, 8'h00, 6'd15), 1'b0);
        // The unused function code is taken but sends nothing.
        offer_request(shaped_request(FUNC_UNUSED,          8'hff, 6'd63), 1'b1);
        offer_request(shaped_request(slcd_pkg::FUNC_CMD,   8'h01, 6'd0),  1'b0);
        offer_request(shaped_request(FUNC_UNUSED,          8'h00, 6'd0),  1'b0);
        offer_request(shaped_request(slcd_pkg::FUNC_CMD,   8'h80, 6'd0),  1'b1);

        // Random part. Cached updates dominate and are steered so that
        // unchanged bytes and single-nibble changes occur often. Words with
        // the unused code are not counted; a run of words in the middle
        // goes out without any gaps.
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                func = FUNC_UNUSED;
            end else if (pick < 25) begin
                func = slcd_pkg::FUNC_CMD;
            end else if (pick < 50) begin
                func = slcd_pkg::FUNC_WRITE;
            end else begin
                func = slcd_pkg::FUNC_CACHE;
            end
            rq = shaped_request(func, 8'($urandom), 6'($urandom));
            if (func == slcd_pkg::FUNC_CACHE) begin
                idx  = rq.byte_index;
                held = predictor.shadow_bytes[idx];
                case ($urandom_range(3))
                    0: rq.byte_value = held;
                    1: rq.byte_value = {held[7:4], 4'($urandom)};
                    2: rq.byte_value = {4'($urandom), held[3:0]};
                    default: begin
                    end
                endcase
            end
            offer_request(rq, !(counted >= 60 && counted < 95));
            if (func != FUNC_UNUSED) counted++;
        end
        i_valid = 1'b0;

        // Drain: wait for every predicted word, then a few more cycles to
        // catch any word that should not come at all.
        while (predictor.pending_bits.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (predictor.mismatch_count == 0 && predictor.pending_bits.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/slcd_pkg.sv
src/slcd_ctl.sv
src/slcd_dp.sv
src/segment_lcd_serial_frame_writer_core.sv
tb/tb_segment_lcd_serial_frame_writer_core.sv
